[hdl/ccsu_pkg.sv]
// Shared types, constants and fixed-point helpers for the cardiac cell stencil update.
package ccsu_pkg;

    localparam int FRAC_BITS = 24;
    localparam int QB        = 34;
    localparam int DW        = 32 + FRAC_BITS;
    localparam int DIV_LAT   = QB + 2;
    localparam int LAT       = DIV_LAT + 5;
    localparam int DLY       = DIV_LAT - 5;

    localparam logic signed [63:0] Q_ONE = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

    localparam int NREG = 8;
    localparam int AW   = 5;

    typedef enum logic [2:0] {
        REG_DIFFUSION_GAIN   = 3'd0,
        REG_TIME_STEP        = 3'd1,
        REG_REACTION_GAIN    = 3'd2,
        REG_EXCITE_THRESHOLD = 3'd3,
        REG_RECOVERY_OFFSET  = 3'd4,
        REG_RECOVERY_RATE    = 3'd5,
        REG_MU_ONE           = 3'd6,
        REG_MU_TWO           = 3'd7
    } reg_idx_t;

    localparam logic [31:0] RST_DIFFUSION_GAIN   = 32'd0;
    localparam logic [31:0] RST_TIME_STEP        = 32'd0;
    localparam logic [31:0] RST_REACTION_GAIN    = 32'd134217728;
    localparam logic [31:0] RST_EXCITE_THRESHOLD = 32'd1677722;
    localparam logic [31:0] RST_RECOVERY_OFFSET  = 32'd1677722;
    localparam logic [31:0] RST_RECOVERY_RATE    = 32'd167772;
    localparam logic [31:0] RST_MU_ONE           = 32'd1174405;
    localparam logic [31:0] RST_MU_TWO           = 32'd5033165;

    typedef struct packed {
        logic signed [31:0] diffusion_gain;
        logic signed [31:0] time_step;
        logic signed [31:0] reaction_gain;
        logic signed [31:0] excite_threshold;
        logic signed [31:0] recovery_offset;
        logic signed [31:0] recovery_rate;
        logic signed [31:0] mu_one;
        logic signed [31:0] mu_two;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               sat;
    } qres_t;

    function automatic logic signed [63:0] sx(input logic signed [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

    function automatic qres_t qclamp(input logic signed [63:0] v);
        qres_t r;
        if (v > Q_MAX)
        begin
            r.val = 32'sh7fffffff;
            r.sat = 1'b1;
        end
        else if (v < Q_MIN)
        begin
            r.val = 32'sh80000000;
            r.sat = 1'b1;
        end
        else
        begin
            r.val = v[31:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    function automatic qres_t qmul(input logic signed [31:0] a, input logic signed [31:0] b);
        logic signed [63:0] p;
        p = sx(a) * sx(b);
        return qclamp(p >>> FRAC_BITS);
    endfunction

endpackage

[hdl/ccsu_regs.sv]
// APB configuration register file.
module ccsu_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ccsu_pkg::AW-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output ccsu_pkg::cfg_t        cfg
);
    import ccsu_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr;

    assign idx    = reg_idx_t'(paddr[AW-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.diffusion_gain   <= RST_DIFFUSION_GAIN;
            cfg_reg.time_step        <= RST_TIME_STEP;
            cfg_reg.reaction_gain    <= RST_REACTION_GAIN;
            cfg_reg.excite_threshold <= RST_EXCITE_THRESHOLD;
            cfg_reg.recovery_offset  <= RST_RECOVERY_OFFSET;
            cfg_reg.recovery_rate    <= RST_RECOVERY_RATE;
            cfg_reg.mu_one           <= RST_MU_ONE;
            cfg_reg.mu_two           <= RST_MU_TWO;
        end
        else if (wr)
        begin
            case (idx)
                REG_DIFFUSION_GAIN:   cfg_reg.diffusion_gain   <= pwdata;
                REG_TIME_STEP:        cfg_reg.time_step        <= pwdata;
                REG_REACTION_GAIN:    cfg_reg.reaction_gain    <= pwdata;
                REG_EXCITE_THRESHOLD: cfg_reg.excite_threshold <= pwdata;
                REG_RECOVERY_OFFSET:  cfg_reg.recovery_offset  <= pwdata;
                REG_RECOVERY_RATE:    cfg_reg.recovery_rate    <= pwdata;
                REG_MU_ONE:           cfg_reg.mu_one           <= pwdata;
                REG_MU_TWO:           cfg_reg.mu_two           <= pwdata;
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_DIFFUSION_GAIN:   prdata = cfg_reg.diffusion_gain;
            REG_TIME_STEP:        prdata = cfg_reg.time_step;
            REG_REACTION_GAIN:    prdata = cfg_reg.reaction_gain;
            REG_EXCITE_THRESHOLD: prdata = cfg_reg.excite_threshold;
            REG_RECOVERY_OFFSET:  prdata = cfg_reg.recovery_offset;
            REG_RECOVERY_RATE:    prdata = cfg_reg.recovery_rate;
            REG_MU_ONE:           prdata = cfg_reg.mu_one;
            REG_MU_TWO:           prdata = cfg_reg.mu_two;
            default:              prdata = 32'd0;
        endcase
    end

endmodule

[hdl/ccsu_div.sv]
// Pipelined restoring divider, one quotient bit per stage, saturating Q-format result.
module ccsu_div (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic signed [31:0] q,
    output logic               qsat
);
    import ccsu_pkg::*;

    logic [DW-1:0] rem_reg  [0:QB];
    logic [31:0]   ad_reg   [0:QB];
    logic [QB-1:0] qb_reg   [0:QB];
    logic          neg_reg  [0:QB];
    logic          zero_reg [0:QB];
    logic          nneg_reg [0:QB];

    logic signed [31:0] q_reg;
    logic               qsat_reg;

    logic [31:0] an;
    logic [31:0] ad;

    assign an = num[31] ? 32'(-num) : num;
    assign ad = den[31] ? 32'(-den) : den;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= DW'(an) << FRAC_BITS;
            ad_reg[0]   <= ad;
            qb_reg[0]   <= '0;
            neg_reg[0]  <= num[31] ^ den[31];
            zero_reg[0] <= (den == 32'sd0);
            nneg_reg[0] <= num[31];
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_bit
        localparam int BI = QB - 1 - k;
        logic [DW-1:0] trial;
        logic          take;
        assign trial = rem_reg[k] >> BI;
        assign take  = (trial >= DW'(ad_reg[k]));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= take ? rem_reg[k] - (DW'(ad_reg[k]) << BI) : rem_reg[k];
                ad_reg[k+1]   <= ad_reg[k];
                qb_reg[k+1]   <= qb_reg[k] | (QB'(take) << BI);
                neg_reg[k+1]  <= neg_reg[k];
                zero_reg[k+1] <= zero_reg[k];
                nneg_reg[k+1] <= nneg_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zero_reg[QB])
            begin
                q_reg    <= nneg_reg[QB] ? 32'sh80000000 : 32'sh7fffffff;
                qsat_reg <= 1'b1;
            end
            else if (!neg_reg[QB] && qb_reg[QB] > QB'(64'd2147483647))
            begin
                q_reg    <= 32'sh7fffffff;
                qsat_reg <= 1'b1;
            end
            else if (neg_reg[QB] && qb_reg[QB] > QB'(64'd2147483648))
            begin
                q_reg    <= 32'sh80000000;
                qsat_reg <= 1'b1;
            end
            else
            begin
                q_reg    <= neg_reg[QB] ? 32'(-qb_reg[QB]) : qb_reg[QB][31:0];
                qsat_reg <= 1'b0;
            end
        end
    end

    assign q    = q_reg;
    assign qsat = qsat_reg;

endmodule

[hdl/cardiac_cell_stencil_update_top.sv]
// Top level of the Aliev-Panfilov cell update pipeline.
//
// One cell enters per transaction on the input channel (valid/ready): its
// center potential, four neighbor potentials and recovery value. One result
// leaves per transaction on the output channel: the new potential, the new
// recovery value and a flag set when any step saturated or the divisor was 0.
// The pipeline is 41 register stages deep; a new cell is taken every cycle
// while the pipeline is not stalled. The length is set by the divider, which
// resolves one quotient bit per stage (34 bits) plus a setup and a saturation
// stage. When the receiver stalls with a result waiting, the whole pipeline
// holds and input ready drops in the same cycle; nothing is lost or repeated.
// Model constants are set through the APB port, one 32-bit register every
// 4 bytes; write them only while the pipeline is empty.
// Reset empties the pipeline and loads the default model constants.
module cardiac_cell_stencil_update_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ccsu_pkg::AW-1:0] paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [31:0]      center_potential,
    input  logic signed [31:0]      north_potential,
    input  logic signed [31:0]      south_potential,
    input  logic signed [31:0]      west_potential,
    input  logic signed [31:0]      east_potential,
    input  logic signed [31:0]      recovery_in,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [31:0]      new_potential,
    output logic signed [31:0]      recovery_out,
    output logic                    saturated
);
    import ccsu_pkg::*;

    cfg_t cfg;
    logic en;
    logic v_reg [1:LAT];

    ccsu_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign en       = !v_reg[LAT] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= LAT; k++)
                v_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[1] <= in_valid;
            for (int k = 2; k <= LAT; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    // stage 1
    logic signed [31:0] s1_c_reg, s1_r_reg, s1_lap_reg, s1_ca_reg, s1_c1_reg;
    logic signed [31:0] s1_den_reg, s1_cbv_reg, s1_kc_reg, s1_cr_reg, s1_num_reg;
    logic               s1_sat_reg;
    qres_t lap_n, ca_n, c1_n, den_n, bb_n, cbv_n, kc_n, cr_n, num_n;

    always_comb
    begin
        lap_n = qclamp(sx(north_potential) + sx(south_potential) + sx(west_potential)
                       + sx(east_potential) - (sx(center_potential) <<< 2));
        ca_n  = qclamp(sx(center_potential) - sx(cfg.excite_threshold));
        c1_n  = qclamp(sx(center_potential) - Q_ONE);
        den_n = qclamp(sx(center_potential) + sx(cfg.mu_two));
        bb_n  = qclamp(sx(cfg.recovery_offset) + Q_ONE);
        cbv_n = qclamp(sx(center_potential) - sx(bb_n.val));
        kc_n  = qmul(cfg.reaction_gain, center_potential);
        cr_n  = qmul(center_potential, recovery_in);
        num_n = qmul(cfg.mu_one, recovery_in);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_c_reg   <= center_potential;
            s1_r_reg   <= recovery_in;
            s1_lap_reg <= lap_n.val;
            s1_ca_reg  <= ca_n.val;
            s1_c1_reg  <= c1_n.val;
            s1_den_reg <= den_n.val;
            s1_cbv_reg <= cbv_n.val;
            s1_kc_reg  <= kc_n.val;
            s1_cr_reg  <= cr_n.val;
            s1_num_reg <= num_n.val;
            s1_sat_reg <= lap_n.sat | ca_n.sat | c1_n.sat | den_n.sat | bb_n.sat
                          | cbv_n.sat | kc_n.sat | cr_n.sat | num_n.sat;
        end
    end

    // stage 2
    logic signed [31:0] s2_c_reg, s2_r_reg, s2_al_reg, s2_kca_reg, s2_k2_reg;
    logic signed [31:0] s2_c1_reg, s2_cr_reg;
    logic               s2_sat_reg;
    qres_t al_n, kca_n, k2_n;

    always_comb
    begin
        al_n  = qmul(cfg.diffusion_gain, s1_lap_reg);
        kca_n = qmul(s1_kc_reg, s1_ca_reg);
        k2_n  = qmul(s1_kc_reg, s1_cbv_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_c_reg   <= s1_c_reg;
            s2_r_reg   <= s1_r_reg;
            s2_al_reg  <= al_n.val;
            s2_kca_reg <= kca_n.val;
            s2_k2_reg  <= k2_n.val;
            s2_c1_reg  <= s1_c1_reg;
            s2_cr_reg  <= s1_cr_reg;
            s2_sat_reg <= s1_sat_reg | al_n.sat | kca_n.sat | k2_n.sat;
        end
    end

    // stage 3
    logic signed [31:0] s3_e_reg, s3_t_reg, s3_h_reg, s3_cr_reg, s3_r_reg;
    logic               s3_sat_reg;
    qres_t e_n, t_n, h_n;

    always_comb
    begin
        e_n = qclamp(sx(s2_c_reg) + sx(s2_al_reg));
        t_n = qmul(s2_kca_reg, s2_c1_reg);
        h_n = qclamp(-sx(s2_r_reg) - sx(s2_k2_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_e_reg   <= e_n.val;
            s3_t_reg   <= t_n.val;
            s3_h_reg   <= h_n.val;
            s3_cr_reg  <= s2_cr_reg;
            s3_r_reg   <= s2_r_reg;
            s3_sat_reg <= s2_sat_reg | e_n.sat | t_n.sat | h_n.sat;
        end
    end

    // stage 4
    logic signed [31:0] s4_e_reg, s4_rx_reg, s4_h_reg, s4_r_reg;
    logic               s4_sat_reg;
    qres_t rx_n;

    assign rx_n = qclamp(sx(s3_t_reg) + sx(s3_cr_reg));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_e_reg   <= s3_e_reg;
            s4_rx_reg  <= rx_n.val;
            s4_h_reg   <= s3_h_reg;
            s4_r_reg   <= s3_r_reg;
            s4_sat_reg <= s3_sat_reg | rx_n.sat;
        end
    end

    // stage 5
    logic signed [31:0] s5_e_reg, s5_dr_reg, s5_h_reg, s5_r_reg;
    logic               s5_sat_reg;
    qres_t dr_n;

    assign dr_n = qmul(cfg.time_step, s4_rx_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_e_reg   <= s4_e_reg;
            s5_dr_reg  <= dr_n.val;
            s5_h_reg   <= s4_h_reg;
            s5_r_reg   <= s4_r_reg;
            s5_sat_reg <= s4_sat_reg | dr_n.sat;
        end
    end

    // stage 6
    logic signed [31:0] s6_pot_reg, s6_h_reg, s6_r_reg;
    logic               s6_sat_reg;
    qres_t pot_n;

    assign pot_n = qclamp(sx(s5_e_reg) - sx(s5_dr_reg));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_pot_reg <= pot_n.val;
            s6_h_reg   <= s5_h_reg;
            s6_r_reg   <= s5_r_reg;
            s6_sat_reg <= s5_sat_reg | pot_n.sat;
        end
    end

    // align with divider
    logic signed [31:0] dl_pot_reg [0:DLY-1];
    logic signed [31:0] dl_h_reg   [0:DLY-1];
    logic signed [31:0] dl_r_reg   [0:DLY-1];
    logic               dl_sat_reg [0:DLY-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl_pot_reg[0] <= s6_pot_reg;
            dl_h_reg[0]   <= s6_h_reg;
            dl_r_reg[0]   <= s6_r_reg;
            dl_sat_reg[0] <= s6_sat_reg;
            for (int k = 1; k < DLY; k++)
            begin
                dl_pot_reg[k] <= dl_pot_reg[k-1];
                dl_h_reg[k]   <= dl_h_reg[k-1];
                dl_r_reg[k]   <= dl_r_reg[k-1];
                dl_sat_reg[k] <= dl_sat_reg[k-1];
            end
        end
    end

    logic signed [31:0] dq;
    logic               dq_sat;

    ccsu_div u_div (
        .clk  (clk),
        .en   (en),
        .num  (s1_num_reg),
        .den  (s1_den_reg),
        .q    (dq),
        .qsat (dq_sat)
    );

    // recovery tail
    logic signed [31:0] t1_g_reg, t1_pot_reg, t1_h_reg, t1_r_reg;
    logic               t1_sat_reg;
    logic signed [31:0] t2_dg_reg, t2_pot_reg, t2_h_reg, t2_r_reg;
    logic               t2_sat_reg;
    logic signed [31:0] t3_u_reg, t3_pot_reg, t3_r_reg;
    logic               t3_sat_reg;
    logic signed [31:0] o_pot_reg, o_rec_reg;
    logic               o_sat_reg;
    qres_t g_n, dg_n, u_n, rec_n;

    always_comb
    begin
        g_n   = qclamp(sx(cfg.recovery_rate) + sx(dq));
        dg_n  = qmul(cfg.time_step, t1_g_reg);
        u_n   = qmul(t2_dg_reg, t2_h_reg);
        rec_n = qclamp(sx(t3_r_reg) + sx(t3_u_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_g_reg   <= g_n.val;
            t1_pot_reg <= dl_pot_reg[DLY-1];
            t1_h_reg   <= dl_h_reg[DLY-1];
            t1_r_reg   <= dl_r_reg[DLY-1];
            t1_sat_reg <= dl_sat_reg[DLY-1] | dq_sat | g_n.sat;

            t2_dg_reg  <= dg_n.val;
            t2_pot_reg <= t1_pot_reg;
            t2_h_reg   <= t1_h_reg;
            t2_r_reg   <= t1_r_reg;
            t2_sat_reg <= t1_sat_reg | dg_n.sat;

            t3_u_reg   <= u_n.val;
            t3_pot_reg <= t2_pot_reg;
            t3_r_reg   <= t2_r_reg;
            t3_sat_reg <= t2_sat_reg | u_n.sat;

            o_pot_reg  <= t3_pot_reg;
            o_rec_reg  <= rec_n.val;
            o_sat_reg  <= t3_sat_reg | rec_n.sat;
        end
    end

    assign out_valid     = v_reg[LAT];
    assign new_potential = o_pot_reg;
    assign recovery_out  = o_rec_reg;
    assign saturated     = o_sat_reg;

endmodule
